// File: design/alm_pkg.sv
`default_nettype none

package alm_pkg;

  localparam int SLOTS      = 64;
  localparam int SLOT_BITS  = $clog2(SLOTS);
  localparam int VALUE_BITS = 32;
  localparam int STEP_BITS  = 5;

  typedef logic [SLOT_BITS-1:0]         slot_t;
  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic [STEP_BITS-1:0]         step_t;

  localparam logic [1:0] KIND_BEFORE = 2'd0;
  localparam logic [1:0] KIND_AFTER  = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;
  localparam logic [1:0] KIND_FIND   = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  localparam step_t S_IDLE       = 5'd0;
  localparam step_t S_INS        = 5'd1;
  localparam step_t S_INS_HEAD   = 5'd2;
  localparam step_t S_INS_RDF0   = 5'd3;
  localparam step_t S_INS_TAKE0  = 5'd4;
  localparam step_t S_INS_RDH    = 5'd5;
  localparam step_t S_INS_WALK   = 5'd6;
  localparam step_t S_INS_RDF    = 5'd7;
  localparam step_t S_INS_TB     = 5'd8;
  localparam step_t S_INS_LP     = 5'd9;
  localparam step_t S_INS_TA     = 5'd10;
  localparam step_t S_INS_LC     = 5'd11;
  localparam step_t S_REM        = 5'd12;
  localparam step_t S_REM_RDH    = 5'd13;
  localparam step_t S_REM_WALK   = 5'd14;
  localparam step_t S_REM_UNL    = 5'd15;
  localparam step_t S_REM_FREE   = 5'd16;
  localparam step_t S_FND        = 5'd17;
  localparam step_t S_FND_RDH    = 5'd18;
  localparam step_t S_FND_WALK   = 5'd19;
  localparam step_t S_FND_HIT    = 5'd20;
  localparam step_t S_DONE_OK    = 5'd21;
  localparam step_t S_DONE_NF    = 5'd22;
  localparam step_t S_DONE_FULL  = 5'd23;
  localparam step_t S_DONE_EMPTY = 5'd24;

  typedef enum logic [3:0] {
    UOP_NOP,
    UOP_RD_HEAD,
    UOP_WALK,
    UOP_RD_FREE,
    UOP_TAKE_EMPTY,
    UOP_TAKE_BEFORE,
    UOP_TAKE_AFTER,
    UOP_LINK_PREV,
    UOP_LINK_CUR,
    UOP_UNLINK,
    UOP_FREE_CUR,
    UOP_FOUND,
    UOP_DONE
  } uop_e;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_ACCEPT,
    COND_FREE_ZERO,
    COND_HEAD_ZERO,
    COND_KIND_AFTER,
    COND_WALK,
    COND_OUT_FREE
  } cond_e;

  typedef struct packed {
    uop_e       uop;
    cond_e      cond;
    step_t      jmp_yes;
    step_t      jmp_no;
    logic [1:0] status;
  } ucode_t;

  typedef struct packed {
    logic   rd_en;
    slot_t  rd_addr;
    logic   lk_we;
    logic   val_we;
    slot_t  wr_addr;
    slot_t  wr_link;
    value_t wr_val;
  } mem_req_t;

  typedef struct packed {
    slot_t  link;
    value_t val;
  } mem_rsp_t;

  function automatic ucode_t alm_ucode(input step_t step);
    ucode_t uc;
    unique case (step)
      S_IDLE:       uc = '{UOP_NOP, COND_ACCEPT, S_IDLE, S_IDLE, ST_OK};
      S_INS:        uc = '{UOP_NOP, COND_FREE_ZERO, S_DONE_FULL, S_INS_HEAD, ST_OK};
      S_INS_HEAD:   uc = '{UOP_NOP, COND_HEAD_ZERO, S_INS_RDF0, S_INS_RDH, ST_OK};
      S_INS_RDF0:   uc = '{UOP_RD_FREE, COND_ALWAYS, S_INS_TAKE0, S_INS_TAKE0, ST_OK};
      S_INS_TAKE0:  uc = '{UOP_TAKE_EMPTY, COND_ALWAYS, S_DONE_OK, S_DONE_OK, ST_OK};
      S_INS_RDH:    uc = '{UOP_RD_HEAD, COND_ALWAYS, S_INS_WALK, S_INS_WALK, ST_OK};
      S_INS_WALK:   uc = '{UOP_WALK, COND_WALK, S_INS_RDF, S_DONE_NF, ST_OK};
      S_INS_RDF:    uc = '{UOP_RD_FREE, COND_KIND_AFTER, S_INS_TA, S_INS_TB, ST_OK};
      S_INS_TB:     uc = '{UOP_TAKE_BEFORE, COND_ALWAYS, S_INS_LP, S_INS_LP, ST_OK};
      S_INS_LP:     uc = '{UOP_LINK_PREV, COND_ALWAYS, S_DONE_OK, S_DONE_OK, ST_OK};
      S_INS_TA:     uc = '{UOP_TAKE_AFTER, COND_ALWAYS, S_INS_LC, S_INS_LC, ST_OK};
      S_INS_LC:     uc = '{UOP_LINK_CUR, COND_ALWAYS, S_DONE_OK, S_DONE_OK, ST_OK};
      S_REM:        uc = '{UOP_NOP, COND_HEAD_ZERO, S_DONE_EMPTY, S_REM_RDH, ST_OK};
      S_REM_RDH:    uc = '{UOP_RD_HEAD, COND_ALWAYS, S_REM_WALK, S_REM_WALK, ST_OK};
      S_REM_WALK:   uc = '{UOP_WALK, COND_WALK, S_REM_UNL, S_DONE_NF, ST_OK};
      S_REM_UNL:    uc = '{UOP_UNLINK, COND_ALWAYS, S_REM_FREE, S_REM_FREE, ST_OK};
      S_REM_FREE:   uc = '{UOP_FREE_CUR, COND_ALWAYS, S_DONE_OK, S_DONE_OK, ST_OK};
      S_FND:        uc = '{UOP_NOP, COND_HEAD_ZERO, S_DONE_NF, S_FND_RDH, ST_OK};
      S_FND_RDH:    uc = '{UOP_RD_HEAD, COND_ALWAYS, S_FND_WALK, S_FND_WALK, ST_OK};
      S_FND_WALK:   uc = '{UOP_WALK, COND_WALK, S_FND_HIT, S_DONE_NF, ST_OK};
      S_FND_HIT:    uc = '{UOP_FOUND, COND_ALWAYS, S_DONE_OK, S_DONE_OK, ST_OK};
      S_DONE_OK:    uc = '{UOP_DONE, COND_OUT_FREE, S_IDLE, S_IDLE, ST_OK};
      S_DONE_NF:    uc = '{UOP_DONE, COND_OUT_FREE, S_IDLE, S_IDLE, ST_NOTFOUND};
      S_DONE_FULL:  uc = '{UOP_DONE, COND_OUT_FREE, S_IDLE, S_IDLE, ST_FULL};
      S_DONE_EMPTY: uc = '{UOP_DONE, COND_OUT_FREE, S_IDLE, S_IDLE, ST_EMPTY};
      default:      uc = '{UOP_NOP, COND_ALWAYS, S_IDLE, S_IDLE, ST_OK};
    endcase
    return uc;
  endfunction

  function automatic step_t alm_dispatch(input logic [1:0] kind);
    step_t s;
    unique case (kind) inside
      KIND_BEFORE, KIND_AFTER: s = S_INS;
      KIND_REMOVE:             s = S_REM;
      default:                 s = S_FND;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// File: design/alm_node_store.sv
`default_nettype none

module alm_node_store (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  alm_pkg::mem_req_t  req_i,
  output alm_pkg::mem_rsp_t  rsp_o
);
  import alm_pkg::*;

  slot_t            link_mem [SLOTS];
  value_t           val_mem  [SLOTS];
  logic [SLOTS-1:0] lk_vld_q;
  slot_t            rd_link_q;
  value_t           rd_val_q;
  slot_t            rd_addr_q;
  logic             rd_vld_q;
  slot_t            dflt_link;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lk_vld_q <= '0;
    end else if (req_i.lk_we) begin
      lk_vld_q[req_i.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.lk_we) begin
      link_mem[req_i.wr_addr] <= req_i.wr_link;
    end
    if (req_i.val_we) begin
      val_mem[req_i.wr_addr] <= req_i.wr_val;
    end
    if (req_i.rd_en) begin
      rd_link_q <= link_mem[req_i.rd_addr];
      rd_val_q  <= val_mem[req_i.rd_addr];
      rd_addr_q <= req_i.rd_addr;
      rd_vld_q  <= lk_vld_q[req_i.rd_addr];
    end
  end

  // A link that was never written still holds its place in the initial free chain.
  always_comb begin
    if (rd_addr_q == '0 || rd_addr_q == slot_t'(SLOTS - 1)) begin
      dflt_link = '0;
    end else begin
      dflt_link = rd_addr_q + slot_t'(1);
    end
  end

  assign rsp_o.link = rd_vld_q ? rd_link_q : dflt_link;
  assign rsp_o.val  = rd_val_q;

endmodule

`default_nettype wire

// File: design/array_linked_list_manager.sv
`default_nettype none

// Channel   Handshake                 Payload
// command   in_valid_i / in_ready_o   kind_i, key_value_i, new_value_i
// result    out_valid_o / out_ready_i status_o, slot_o, is_empty_o, is_full_o
//
// From acceptance to result a command runs through the microcode steps of its kind, the walk
// visiting list nodes in turn, and the sequencer returns to idle before the next command is taken.
// The walk reads one node per cycle from the link and value memories.
// Reset empties the list and chains every slot but the null slot 0 into the free list at once.
// A new command is taken only when the sequencer is idle; a result waiting in the
// output register stalls the sequencer only at its final step.

module array_linked_list_manager (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          kind_i,
  input  logic signed [alm_pkg::VALUE_BITS-1:0] key_value_i,
  input  logic signed [alm_pkg::VALUE_BITS-1:0] new_value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [1:0]                          status_o,
  output logic [alm_pkg::SLOT_BITS-1:0]       slot_o,
  output logic                                is_empty_o,
  output logic                                is_full_o
);
  import alm_pkg::*;

  step_t      step_q, step_d;
  ucode_t     uw;
  mem_req_t   mreq;
  mem_rsp_t   mrsp;
  logic       match;
  logic       out_free;

  logic [1:0] kind_q, kind_d;
  value_t     key_q, key_d;
  value_t     nv_q, nv_d;
  slot_t      cur_q, cur_d;
  slot_t      prev_q, prev_d;
  slot_t      next_q, next_d;
  slot_t      slot_q, slot_d;
  slot_t      head_q, head_d;
  slot_t      free_q, free_d;

  logic       out_valid_q, out_valid_d;
  logic [1:0] out_status_q, out_status_d;
  slot_t      out_slot_q, out_slot_d;
  logic       out_empty_q, out_empty_d;
  logic       out_full_q, out_full_d;

  alm_node_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .rsp_o  (mrsp)
  );

  assign uw         = alm_ucode(step_q);
  assign match      = (mrsp.val == key_q);
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (step_q == S_IDLE);

  always_comb begin
    kind_d       = kind_q;
    key_d        = key_q;
    nv_d         = nv_q;
    cur_d        = cur_q;
    prev_d       = prev_q;
    next_d       = next_q;
    slot_d       = slot_q;
    head_d       = head_q;
    free_d       = free_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_empty_d  = out_empty_q;
    out_full_d   = out_full_q;
    mreq         = '0;

    if (in_valid_i && in_ready_o) begin
      kind_d = kind_i;
      key_d  = key_value_i;
      nv_d   = new_value_i;
    end

    unique case (uw.uop)
      UOP_RD_HEAD: begin
        mreq.rd_en   = 1'b1;
        mreq.rd_addr = head_q;
        cur_d        = head_q;
        prev_d       = '0;
      end
      UOP_WALK: begin
        if (match) begin
          next_d = mrsp.link;
        end else if (mrsp.link != '0) begin
          prev_d       = cur_q;
          cur_d        = mrsp.link;
          mreq.rd_en   = 1'b1;
          mreq.rd_addr = mrsp.link;
        end
      end
      UOP_RD_FREE: begin
        mreq.rd_en   = 1'b1;
        mreq.rd_addr = free_q;
      end
      UOP_TAKE_EMPTY, UOP_TAKE_BEFORE, UOP_TAKE_AFTER: begin
        slot_d       = free_q;
        free_d       = mrsp.link;
        mreq.lk_we   = 1'b1;
        mreq.val_we  = 1'b1;
        mreq.wr_addr = free_q;
        mreq.wr_val  = nv_q;
        if (uw.uop == UOP_TAKE_EMPTY) begin
          mreq.wr_link = '0;
          head_d       = free_q;
        end else if (uw.uop == UOP_TAKE_BEFORE) begin
          mreq.wr_link = cur_q;
        end else begin
          mreq.wr_link = next_q;
        end
      end
      UOP_LINK_PREV: begin
        if (prev_q != '0) begin
          mreq.lk_we   = 1'b1;
          mreq.wr_addr = prev_q;
          mreq.wr_link = slot_q;
        end else begin
          head_d = slot_q;
        end
      end
      UOP_LINK_CUR: begin
        mreq.lk_we   = 1'b1;
        mreq.wr_addr = cur_q;
        mreq.wr_link = slot_q;
      end
      UOP_UNLINK: begin
        if (prev_q != '0) begin
          mreq.lk_we   = 1'b1;
          mreq.wr_addr = prev_q;
          mreq.wr_link = next_q;
        end else begin
          head_d = next_q;
        end
      end
      UOP_FREE_CUR: begin
        mreq.lk_we   = 1'b1;
        mreq.wr_addr = cur_q;
        mreq.wr_link = free_q;
        free_d       = cur_q;
        slot_d       = cur_q;
      end
      UOP_FOUND: begin
        slot_d = cur_q;
      end
      UOP_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = uw.status;
          out_slot_d   = (uw.status == ST_OK) ? slot_q : '0;
          out_empty_d  = (head_q == '0);
          out_full_d   = (free_q == '0);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    step_d = step_q;
    unique case (uw.cond)
      COND_ALWAYS:     step_d = uw.jmp_yes;
      COND_ACCEPT:     step_d = in_valid_i ? alm_dispatch(kind_i) : step_q;
      COND_FREE_ZERO:  step_d = (free_q == '0) ? uw.jmp_yes : uw.jmp_no;
      COND_HEAD_ZERO:  step_d = (head_q == '0) ? uw.jmp_yes : uw.jmp_no;
      COND_KIND_AFTER: step_d = (kind_q == KIND_AFTER) ? uw.jmp_yes : uw.jmp_no;
      COND_WALK: begin
        if (match) begin
          step_d = uw.jmp_yes;
        end else if (mrsp.link == '0) begin
          step_d = uw.jmp_no;
        end
      end
      COND_OUT_FREE:   step_d = out_free ? uw.jmp_yes : step_q;
      default:         step_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= S_IDLE;
      head_q      <= '0;
      free_q      <= slot_t'(1);
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      head_q      <= head_d;
      free_q      <= free_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    key_q        <= key_d;
    nv_q         <= nv_d;
    cur_q        <= cur_d;
    prev_q       <= prev_d;
    next_q       <= next_d;
    slot_q       <= slot_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
    out_empty_q  <= out_empty_d;
    out_full_q   <= out_full_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign slot_o      = out_slot_q;
  assign is_empty_o  = out_empty_q;
  assign is_full_o   = out_full_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("sequencer still ready after taking a command");

  a_no_null_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mreq.rd_en |-> (mreq.rd_addr != '0))
    else $error("read issued at the null slot");

  a_fail_no_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_OK)) |-> (slot_o == '0))
    else $error("failed command reports a slot");

  a_not_empty_and_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(is_empty_o && is_full_o))
    else $error("list reported empty and full at once");

endmodule

`default_nettype wire
